// ----- src/laser_point_interpolator_macros.svh -----
// Assertion macros shared by the checker of the laser point interpolator.
`ifndef LASER_POINT_INTERPOLATOR_MACROS_SVH
`define LASER_POINT_INTERPOLATOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define LPI_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define LPI_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/lpi_pkg.sv -----
// Shared constants and payload types of the laser point interpolator.
`timescale 1ns / 1ps

package lpi_pkg;

    localparam int COORD_BITS   = 12;
    localparam int COLOR_BITS   = 8;
    localparam int SPACING_BITS = 12;
    localparam int MAX_STEPS    = 62;

    // signed coordinate difference and segment length
    localparam int DIST_BITS = COORD_BITS + 1;
    // sum of two squares
    localparam int SQ_BITS   = 2 * DIST_BITS;
    localparam int STEP_BITS = $clog2(MAX_STEPS + 1);
    // iteration counters of the serial units
    localparam int CNT_BITS  = $clog2(DIST_BITS + 1);

    localparam logic [SPACING_BITS-1:0] SPACING_RESET = SPACING_BITS'(100);

    localparam logic KIND_POINT = 1'b0;
    localparam logic KIND_COLOR = 1'b1;

    typedef struct packed {
        logic [COORD_BITS-1:0] in_x;
        logic [COORD_BITS-1:0] in_y;
        logic [COLOR_BITS-1:0] in_red;
        logic [COLOR_BITS-1:0] in_green;
        logic [COLOR_BITS-1:0] in_blue;
        logic                  first_of_segment;
        logic                  last_of_segment;
    } in_item_t;

    typedef struct packed {
        logic                  out_kind;
        logic [COORD_BITS-1:0] out_x;
        logic [COORD_BITS-1:0] out_y;
        logic [COLOR_BITS-1:0] out_red;
        logic [COLOR_BITS-1:0] out_green;
        logic [COLOR_BITS-1:0] out_blue;
        logic                  out_last;
    } out_item_t;

endpackage

// ----- src/laser_point_interpolator.sv -----
// Laser point interpolator: takes one polyline point per transfer and emits the
// plotted points and colour changes that follow from it, one result per transfer
// on the output. A point that opens a segment gives 2 or 3 results. Any other
// point first runs through the serial arithmetic: a start, shift-add squaring, a
// square root (two radicand bits per cycle), a division of the length by
// step_spacing and a division of both axis differences by the step count, each
// division one quotient bit per cycle. The n inserted points (n up to 62) then
// leave one per cycle while the output takes them, followed by the point itself
// and any colour result. With no point inserted the length division ends it;
// zero spacing skips that division and uses n = 62. A zero-length move skips the
// divisions. The output register holds one result, so the next point is taken
// while the last result still waits. step_spacing resets to 100; the user must
// write it through the cfg channel only while no point is in progress, and the
// block itself does not enforce this.
`timescale 1ns / 1ps

module laser_point_interpolator
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  lpi_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output lpi_pkg::out_item_t                   out_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lpi_pkg::SPACING_BITS-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIST,
        S_NDIV,
        S_ADIV,
        S_STEP,
        S_POINT,
        S_COLOR,
        S_BLACK
    } state_t;

    localparam int CB = lpi_pkg::COORD_BITS;
    localparam int DB = lpi_pkg::DIST_BITS;
    localparam int SB = lpi_pkg::STEP_BITS;
    localparam int PB = lpi_pkg::SPACING_BITS;

    state_t                  state_reg, state_next;
    lpi_pkg::in_item_t       cur_reg, cur_next;
    logic [CB-1:0]           prev_x_reg, prev_x_next;
    logic [CB-1:0]           prev_y_reg, prev_y_next;
    logic [PB-1:0]           spacing_reg, spacing_next;
    logic                    neg_x_reg, neg_x_next;
    logic                    neg_y_reg, neg_y_next;
    logic [CB-1:0]           mag_x_reg, mag_x_next;
    logic [CB-1:0]           mag_y_reg, mag_y_next;
    logic [SB-1:0]           n_reg, n_next;
    logic [DB-1:0]           qd_x_reg, qd_x_next;
    logic [DB-1:0]           qd_y_reg, qd_y_next;
    logic [SB-1:0]           rd_x_reg, rd_x_next;
    logic [SB-1:0]           rd_y_reg, rd_y_next;
    logic [DB-1:0]           q_x_reg, q_x_next;
    logic [DB-1:0]           q_y_reg, q_y_next;
    logic [SB-1:0]           r_x_reg, r_x_next;
    logic [SB-1:0]           r_y_reg, r_y_next;
    logic [SB-1:0]           step_cnt_reg, step_cnt_next;
    logic                    dist_start_reg, dist_start_next;
    logic                    div_start_reg, div_start_next;
    logic [DB-1:0]           diva_num_reg, diva_num_next;
    logic [PB-1:0]           diva_den_reg, diva_den_next;
    logic [DB-1:0]           divb_num_reg, divb_num_next;
    logic [PB-1:0]           divb_den_reg, divb_den_next;
    logic                    out_valid_reg, out_valid_next;
    lpi_pkg::out_item_t      out_data_reg, out_data_next;

    logic                    dist_done;
    logic [DB-1:0]           dist_value;
    logic                    diva_done;
    logic [DB-1:0]           diva_quo;
    logic [PB-1:0]           diva_rem;
    logic                    divb_done;
    logic [DB-1:0]           divb_quo;
    logic [PB-1:0]           divb_rem;

    logic                    in_xfer;
    logic                    out_free;
    logic [DB-1:0]           dx_new;
    logic [DB-1:0]           dy_new;
    logic [SB-1:0]           n_sat;
    logic [SB-1:0]           rem_x;
    logic [SB-1:0]           rem_y;
    logic [SB:0]             rsum_x;
    logic [SB:0]             rsum_y;
    logic                    carry_x;
    logic                    carry_y;
    logic [DB-1:0]           q_x_step;
    logic [DB-1:0]           q_y_step;

    lpi_dist u_dist
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (dist_start_reg),
        .mag_x (mag_x_reg),
        .mag_y (mag_y_reg),
        .done  (dist_done),
        .len   (dist_value)
    );

    // divider A does length / spacing, then |dx| / n; divider B does |dy| / n
    lpi_div u_div_a
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (diva_num_reg),
        .den   (diva_den_reg),
        .done  (diva_done),
        .quo   (diva_quo),
        .rem   (diva_rem)
    );

    lpi_div u_div_b
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (divb_num_reg),
        .den   (divb_den_reg),
        .done  (divb_done),
        .quo   (divb_quo),
        .rem   (divb_rem)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_xfer   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;

    assign dx_new = {1'b0, in_data.in_x} - {1'b0, prev_x_reg};
    assign dy_new = {1'b0, in_data.in_y} - {1'b0, prev_y_reg};

    assign n_sat = (diva_quo > DB'(lpi_pkg::MAX_STEPS)) ? SB'(lpi_pkg::MAX_STEPS)
                                                          : diva_quo[SB-1:0];
    assign rem_x = diva_rem[SB-1:0];
    assign rem_y = divb_rem[SB-1:0];

    // running floor(i*d/n) kept as quotient plus remainder below n
    assign rsum_x   = {1'b0, r_x_reg} + {1'b0, rd_x_reg};
    assign rsum_y   = {1'b0, r_y_reg} + {1'b0, rd_y_reg};
    assign carry_x  = (rsum_x >= {1'b0, n_reg});
    assign carry_y  = (rsum_y >= {1'b0, n_reg});
    assign q_x_step = q_x_reg + qd_x_reg + DB'(carry_x);
    assign q_y_step = q_y_reg + qd_y_reg + DB'(carry_y);

    always_comb
    begin
        state_next      = state_reg;
        cur_next        = cur_reg;
        prev_x_next     = prev_x_reg;
        prev_y_next     = prev_y_reg;
        spacing_next    = spacing_reg;
        neg_x_next      = neg_x_reg;
        neg_y_next      = neg_y_reg;
        mag_x_next      = mag_x_reg;
        mag_y_next      = mag_y_reg;
        n_next          = n_reg;
        qd_x_next       = qd_x_reg;
        qd_y_next       = qd_y_reg;
        rd_x_next       = rd_x_reg;
        rd_y_next       = rd_y_reg;
        q_x_next        = q_x_reg;
        q_y_next        = q_y_reg;
        r_x_next        = r_x_reg;
        r_y_next        = r_y_reg;
        step_cnt_next   = step_cnt_reg;
        dist_start_next = 1'b0;
        div_start_next  = 1'b0;
        diva_num_next   = diva_num_reg;
        diva_den_next   = diva_den_reg;
        divb_num_next   = divb_num_reg;
        divb_den_next   = divb_den_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_data_next   = out_data_reg;

        if (cfg_valid)
        begin
            spacing_next = cfg_data;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    cur_next   = in_data;
                    neg_x_next = dx_new[DB-1];
                    neg_y_next = dy_new[DB-1];
                    mag_x_next = dx_new[DB-1] ? CB'(DB'(0) - dx_new) : dx_new[CB-1:0];
                    mag_y_next = dy_new[DB-1] ? CB'(DB'(0) - dy_new) : dy_new[CB-1:0];
                    if (in_data.first_of_segment)
                    begin
                        state_next = S_POINT;
                    end
                    else
                    begin
                        dist_start_next = 1'b1;
                        state_next      = S_DIST;
                    end
                end
            end
            S_DIST:
            begin
                if (dist_done)
                begin
                    if (dist_value == '0)
                    begin
                        state_next = S_POINT;
                    end
                    else if (spacing_reg == '0)
                    begin
                        n_next         = SB'(lpi_pkg::MAX_STEPS);
                        diva_num_next  = {1'b0, mag_x_reg};
                        diva_den_next  = PB'(lpi_pkg::MAX_STEPS);
                        divb_num_next  = {1'b0, mag_y_reg};
                        divb_den_next  = PB'(lpi_pkg::MAX_STEPS);
                        div_start_next = 1'b1;
                        state_next     = S_ADIV;
                    end
                    else
                    begin
                        diva_num_next  = dist_value;
                        diva_den_next  = spacing_reg;
                        div_start_next = 1'b1;
                        state_next     = S_NDIV;
                    end
                end
            end
            S_NDIV:
            begin
                if (diva_done)
                begin
                    n_next = n_sat;
                    if (n_sat == '0)
                    begin
                        state_next = S_POINT;
                    end
                    else
                    begin
                        diva_num_next  = {1'b0, mag_x_reg};
                        diva_den_next  = {{(PB - SB){1'b0}}, n_sat};
                        divb_num_next  = {1'b0, mag_y_reg};
                        divb_den_next  = {{(PB - SB){1'b0}}, n_sat};
                        div_start_next = 1'b1;
                        state_next     = S_ADIV;
                    end
                end
            end
            S_ADIV:
            begin
                // both dividers run in lockstep and finish together
                if (diva_done && divb_done)
                begin
                    // floor division of a negative difference rounds away from zero
                    if (neg_x_reg)
                    begin
                        qd_x_next = DB'(0) - diva_quo - DB'(rem_x != '0);
                        rd_x_next = (rem_x != '0) ? n_reg - rem_x : '0;
                    end
                    else
                    begin
                        qd_x_next = diva_quo;
                        rd_x_next = rem_x;
                    end
                    if (neg_y_reg)
                    begin
                        qd_y_next = DB'(0) - divb_quo - DB'(rem_y != '0);
                        rd_y_next = (rem_y != '0) ? n_reg - rem_y : '0;
                    end
                    else
                    begin
                        qd_y_next = divb_quo;
                        rd_y_next = rem_y;
                    end
                    q_x_next      = '0;
                    q_y_next      = '0;
                    r_x_next      = '0;
                    r_y_next      = '0;
                    step_cnt_next = '0;
                    state_next    = S_STEP;
                end
            end
            S_STEP:
            begin
                if (out_free)
                begin
                    q_x_next = q_x_step;
                    q_y_next = q_y_step;
                    r_x_next = carry_x ? SB'(rsum_x - {1'b0, n_reg}) : rsum_x[SB-1:0];
                    r_y_next = carry_y ? SB'(rsum_y - {1'b0, n_reg}) : rsum_y[SB-1:0];
                    out_valid_next          = 1'b1;
                    out_data_next           = '0;
                    out_data_next.out_kind  = lpi_pkg::KIND_POINT;
                    out_data_next.out_x     = prev_x_reg + q_x_step[CB-1:0];
                    out_data_next.out_y     = prev_y_reg + q_y_step[CB-1:0];
                    step_cnt_next           = step_cnt_reg + 1'b1;
                    if (step_cnt_reg + 1'b1 == n_reg)
                    begin
                        state_next = S_POINT;
                    end
                end
            end
            S_POINT:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next           = '0;
                    out_data_next.out_kind  = lpi_pkg::KIND_POINT;
                    out_data_next.out_x     = cur_reg.in_x;
                    out_data_next.out_y     = cur_reg.in_y;
                    out_data_next.out_last  = !cur_reg.first_of_segment
                                              && !cur_reg.last_of_segment;
                    prev_x_next = cur_reg.in_x;
                    prev_y_next = cur_reg.in_y;
                    if (cur_reg.first_of_segment)
                    begin
                        state_next = S_COLOR;
                    end
                    else if (cur_reg.last_of_segment)
                    begin
                        state_next = S_BLACK;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_COLOR:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next           = '0;
                    out_data_next.out_kind  = lpi_pkg::KIND_COLOR;
                    out_data_next.out_red   = cur_reg.in_red;
                    out_data_next.out_green = cur_reg.in_green;
                    out_data_next.out_blue  = cur_reg.in_blue;
                    out_data_next.out_last  = !cur_reg.last_of_segment;
                    state_next = cur_reg.last_of_segment ? S_BLACK : S_IDLE;
                end
            end
            S_BLACK:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_data_next           = '0;
                    out_data_next.out_kind  = lpi_pkg::KIND_COLOR;
                    out_data_next.out_last  = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cur_reg        <= '0;
            prev_x_reg     <= '0;
            prev_y_reg     <= '0;
            spacing_reg    <= lpi_pkg::SPACING_RESET;
            neg_x_reg      <= 1'b0;
            neg_y_reg      <= 1'b0;
            mag_x_reg      <= '0;
            mag_y_reg      <= '0;
            n_reg          <= '0;
            qd_x_reg       <= '0;
            qd_y_reg       <= '0;
            rd_x_reg       <= '0;
            rd_y_reg       <= '0;
            q_x_reg        <= '0;
            q_y_reg        <= '0;
            r_x_reg        <= '0;
            r_y_reg        <= '0;
            step_cnt_reg   <= '0;
            dist_start_reg <= 1'b0;
            div_start_reg  <= 1'b0;
            diva_num_reg   <= '0;
            diva_den_reg   <= '0;
            divb_num_reg   <= '0;
            divb_den_reg   <= '0;
            out_valid_reg  <= 1'b0;
            out_data_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cur_reg        <= cur_next;
            prev_x_reg     <= prev_x_next;
            prev_y_reg     <= prev_y_next;
            spacing_reg    <= spacing_next;
            neg_x_reg      <= neg_x_next;
            neg_y_reg      <= neg_y_next;
            mag_x_reg      <= mag_x_next;
            mag_y_reg      <= mag_y_next;
            n_reg          <= n_next;
            qd_x_reg       <= qd_x_next;
            qd_y_reg       <= qd_y_next;
            rd_x_reg       <= rd_x_next;
            rd_y_reg       <= rd_y_next;
            q_x_reg        <= q_x_next;
            q_y_reg        <= q_y_next;
            r_x_reg        <= r_x_next;
            r_y_reg        <= r_y_next;
            step_cnt_reg   <= step_cnt_next;
            dist_start_reg <= dist_start_next;
            div_start_reg  <= div_start_next;
            diva_num_reg   <= diva_num_next;
            diva_den_reg   <= diva_den_next;
            divb_num_reg   <= divb_num_next;
            divb_den_reg   <= divb_den_next;
            out_valid_reg  <= out_valid_next;
            out_data_reg   <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ----- src/lpi_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle.
`timescale 1ns / 1ps

module lpi_div
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [lpi_pkg::DIST_BITS-1:0]       num,
    input  logic [lpi_pkg::SPACING_BITS-1:0]    den,
    output logic                                done,
    output logic [lpi_pkg::DIST_BITS-1:0]       quo,
    output logic [lpi_pkg::SPACING_BITS-1:0]    rem
);

    typedef enum logic {
        V_IDLE,
        V_RUN
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic [lpi_pkg::CNT_BITS-1:0]        cnt_reg, cnt_next;
    logic [lpi_pkg::DIST_BITS-1:0]       num_reg, num_next;
    logic [lpi_pkg::SPACING_BITS-1:0]    rem_reg, rem_next;
    logic [lpi_pkg::SPACING_BITS-1:0]    den_reg, den_next;
    logic                                done_reg, done_next;
    logic [lpi_pkg::SPACING_BITS:0]      trial;
    logic                                fits;

    // partial remainder with the next dividend bit brought down
    assign trial = {rem_reg, num_reg[lpi_pkg::DIST_BITS-1]};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        done_next  = 1'b0;
        case (phase_reg)
            V_IDLE:
            begin
                if (start)
                begin
                    num_next   = num;
                    den_next   = den;
                    rem_next   = '0;
                    cnt_next   = '0;
                    phase_next = V_RUN;
                end
            end
            V_RUN:
            begin
                if (fits)
                begin
                    rem_next = lpi_pkg::SPACING_BITS'(trial - {1'b0, den_reg});
                end
                else
                begin
                    rem_next = trial[lpi_pkg::SPACING_BITS-1:0];
                end
                num_next = {num_reg[lpi_pkg::DIST_BITS-2:0], fits};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lpi_pkg::CNT_BITS'(lpi_pkg::DIST_BITS - 1))
                begin
                    done_next  = 1'b1;
                    phase_next = V_IDLE;
                end
            end
            default:
            begin
                phase_next = V_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= V_IDLE;
            cnt_reg   <= '0;
            num_reg   <= '0;
            rem_reg   <= '0;
            den_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            num_reg   <= num_next;
            rem_reg   <= rem_next;
            den_reg   <= den_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;
    assign quo  = num_reg;
    assign rem  = rem_reg;

endmodule

// ----- src/lpi_dist.sv -----
// Segment length: serial shift-add squares, then a two-bits-per-cycle square root.
`timescale 1ns / 1ps

module lpi_dist
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [lpi_pkg::COORD_BITS-1:0]   mag_x,
    input  logic [lpi_pkg::COORD_BITS-1:0]   mag_y,
    output logic                             done,
    output logic [lpi_pkg::DIST_BITS-1:0]    len
);

    typedef enum logic [1:0] {
        D_IDLE,
        D_SQUARE,
        D_ROOT
    } phase_t;

    localparam int RAD_BITS = lpi_pkg::DIST_BITS + 3;
    localparam int REM_BITS = lpi_pkg::DIST_BITS + 1;

    phase_t                             phase_reg, phase_next;
    logic [lpi_pkg::CNT_BITS-1:0]       cnt_reg, cnt_next;
    logic [lpi_pkg::SQ_BITS-1:0]        mcx_reg, mcx_next;
    logic [lpi_pkg::SQ_BITS-1:0]        mcy_reg, mcy_next;
    logic [lpi_pkg::COORD_BITS-1:0]     mlx_reg, mlx_next;
    logic [lpi_pkg::COORD_BITS-1:0]     mly_reg, mly_next;
    logic [lpi_pkg::SQ_BITS-1:0]        acc_reg, acc_next;
    logic [REM_BITS-1:0]                rem_reg, rem_next;
    logic [lpi_pkg::DIST_BITS-1:0]      root_reg, root_next;
    logic                               done_reg, done_next;
    logic [RAD_BITS-1:0]                rad;
    logic [RAD_BITS-1:0]                trial;

    // remainder with the next two radicand bits, against 4*root + 1
    assign rad   = {rem_reg, acc_reg[lpi_pkg::SQ_BITS-1 -: 2]};
    assign trial = {1'b0, root_reg, 2'b01};

    always_comb
    begin
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        mcx_next   = mcx_reg;
        mcy_next   = mcy_reg;
        mlx_next   = mlx_reg;
        mly_next   = mly_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        done_next  = 1'b0;
        case (phase_reg)
            D_IDLE:
            begin
                if (start)
                begin
                    mcx_next   = lpi_pkg::SQ_BITS'(mag_x);
                    mcy_next   = lpi_pkg::SQ_BITS'(mag_y);
                    mlx_next   = mag_x;
                    mly_next   = mag_y;
                    acc_next   = '0;
                    cnt_next   = '0;
                    phase_next = D_SQUARE;
                end
            end
            D_SQUARE:
            begin
                acc_next = acc_reg + (mlx_reg[0] ? mcx_reg : '0)
                                   + (mly_reg[0] ? mcy_reg : '0);
                mcx_next = mcx_reg << 1;
                mcy_next = mcy_reg << 1;
                mlx_next = mlx_reg >> 1;
                mly_next = mly_reg >> 1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lpi_pkg::CNT_BITS'(lpi_pkg::COORD_BITS - 1))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    root_next  = '0;
                    phase_next = D_ROOT;
                end
            end
            D_ROOT:
            begin
                if (rad >= trial)
                begin
                    rem_next  = REM_BITS'(rad - trial);
                    root_next = {root_reg[lpi_pkg::DIST_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rad[REM_BITS-1:0];
                    root_next = {root_reg[lpi_pkg::DIST_BITS-2:0], 1'b0};
                end
                acc_next = acc_reg << 2;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == lpi_pkg::CNT_BITS'(lpi_pkg::DIST_BITS - 1))
                begin
                    done_next  = 1'b1;
                    phase_next = D_IDLE;
                end
            end
            default:
            begin
                phase_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= D_IDLE;
            cnt_reg   <= '0;
            mcx_reg   <= '0;
            mcy_reg   <= '0;
            mlx_reg   <= '0;
            mly_reg   <= '0;
            acc_reg   <= '0;
            rem_reg   <= '0;
            root_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            mcx_reg   <= mcx_next;
            mcy_reg   <= mcy_next;
            mlx_reg   <= mlx_next;
            mly_reg   <= mly_next;
            acc_reg   <= acc_next;
            rem_reg   <= rem_next;
            root_reg  <= root_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;
    assign len  = root_reg;

endmodule

// ----- src/lpi_checker.sv -----
// Port-level checks of the laser point interpolator, bound to the top level.
`timescale 1ns / 1ps
`include "laser_point_interpolator_macros.svh"

module lpi_checker
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input lpi_pkg::out_item_t    out_data
);

    // a held result must not change under a stall
    `LPI_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

    // one point at a time: the input closes right after a transfer
    `LPI_ASSERT_NEXT(a_in_closes, in_valid && in_ready, !in_ready, "input open after a transfer")

    `LPI_ASSERT_NOW(a_color_no_xy, out_valid && out_data.out_kind == lpi_pkg::KIND_COLOR, out_data.out_x == '0 && out_data.out_y == '0, "colour result with coordinates")

    `LPI_ASSERT_NOW(a_point_no_rgb, out_valid && out_data.out_kind == lpi_pkg::KIND_POINT, out_data.out_red == '0 && out_data.out_green == '0 && out_data.out_blue == '0, "point result with colour")

endmodule

bind laser_point_interpolator lpi_checker u_lpi_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
